@@ design/iot_pkg.sv @@
// Shared constants and types for the interval overlay table.
// Used by iot_ctrl and interval_overlay_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package iot_pkg;

	// Default sizes of the table and of the range fields.
	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_OFFSET_BITS   = 48;
	localparam int DEF_LENGTH_BITS   = 27;

	// Fixed field widths.
	localparam int OWNER_BITS  = 32;
	localparam int RANK_BITS   = 6;
	localparam int STATUS_BITS = 3;
	localparam int TOTAL_BITS  = 7;

	// Result status codes.
	localparam logic [STATUS_BITS-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd1;
	localparam logic [STATUS_BITS-1:0] STAT_ZERO_LEN = 3'd2;
	localparam logic [STATUS_BITS-1:0] STAT_RANK     = 3'd3;
	localparam logic [STATUS_BITS-1:0] STAT_END_OVF  = 3'd4;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_RDATA,
		ST_SCAN,
		ST_CALC,
		ST_MOVE,
		ST_PUT,
		ST_EMIT
	} iot_state_t;

endpackage
`default_nettype wire

@@ design/iot_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module iot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/iot_ctrl.sv @@
// Sequencer of the interval overlay table: scans, shifts and rewrites the entry RAM.
// Depends on iot_pkg; drives the ports of one iot_ram instance.
`timescale 1ns / 1ps
`default_nettype none
module iot_ctrl import iot_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS,
	localparam int IDX_BITS   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_BITS   = $clog2(TABLE_ENTRIES + 1),
	localparam int ENTRY_BITS = OFFSET_BITS + LENGTH_BITS + OWNER_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   mode,
	input  wire logic [OFFSET_BITS-1:0] range_start,
	input  wire logic [LENGTH_BITS-1:0] range_length,
	input  wire logic [OWNER_BITS-1:0]  owner_id,
	input  wire logic [RANK_BITS-1:0]   read_rank,
	output logic      [IDX_BITS-1:0]    ram_raddr,
	input  wire logic [ENTRY_BITS-1:0]  ram_rdata,
	output logic                        ram_we,
	output logic      [IDX_BITS-1:0]    ram_waddr,
	output logic      [ENTRY_BITS-1:0]  ram_wdata,
	output logic                        res_valid,
	input  wire logic                   res_free,
	output logic      [STATUS_BITS-1:0] res_status,
	output logic      [OFFSET_BITS-1:0] res_start,
	output logic      [LENGTH_BITS-1:0] res_length,
	output logic      [OWNER_BITS-1:0]  res_owner,
	output logic      [TOTAL_BITS-1:0]  res_total
);

	localparam int SUM_BITS = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;
	localparam int DLT_BITS = CNT_BITS + 2;

	iot_state_t state_q, state_d;

	// Captured transaction.
	logic                   mode_q;
	logic [OFFSET_BITS-1:0] ns_q, nlast_q;
	logic [LENGTH_BITS-1:0] nl_q;
	logic [OWNER_BITS-1:0]  no_q;
	logic [RANK_BITS-1:0]   rank_q;

	// Table bookkeeping and walk state.
	logic [CNT_BITS-1:0]    occ_q, new_occ_q, issue_q, remain_q, lo_q, hi_q, idx_s1;
	logic                   vld_s1, found_q, stop_q, left_q, right_q;
	logic [OFFSET_BITS-1:0] ls_q, last_end_q;
	logic [OWNER_BITS-1:0]  lown_q, rown_q;
	logic [DLT_BITS-1:0]    delta_q;
	logic [1:0]             piece_q;

	// Result held until the output register takes it.
	logic [STATUS_BITS-1:0] res_status_q;
	logic [OFFSET_BITS-1:0] res_start_q;
	logic [LENGTH_BITS-1:0] res_length_q;
	logic [OWNER_BITS-1:0]  res_owner_q;
	logic [CNT_BITS-1:0]    res_occ_q;
	logic [CNT_BITS+TOTAL_BITS-1:0] total_ext;

	// Unpacked read data and derived values.
	logic [OFFSET_BITS-1:0] rd_start;
	logic [LENGTH_BITS-1:0] rd_len;
	logic [OWNER_BITS-1:0]  rd_own;
	logic [SUM_BITS-1:0]    rd_end, ns_ext, nlast_sum;
	logic                   end_ovf, consume, stop_now, scan_issue, scan_done;
	logic                   rank_ok, move_issue, delta_pos, right_c, full_c;
	logic [CNT_BITS+RANK_BITS-1:0] rank_ext, occ_rext;
	logic [CNT_BITS-1:0]    touched_c;
	logic [CNT_BITS:0]      count_c, addr_new, addr_right;
	logic [DLT_BITS-1:0]    delta_c, dest_sum;
	logic [SUM_BITS-1:0]    left_len, right_len;

	assign rd_start = ram_rdata[ENTRY_BITS-1 -: OFFSET_BITS];
	assign rd_len   = ram_rdata[OWNER_BITS+LENGTH_BITS-1 -: LENGTH_BITS];
	assign rd_own   = ram_rdata[OWNER_BITS-1:0];

	// Last covered offset of the stored entry and of the new range.
	assign rd_end    = {{(SUM_BITS-OFFSET_BITS){1'b0}}, rd_start}
		+ {{(SUM_BITS-LENGTH_BITS){1'b0}}, rd_len} - {{(SUM_BITS-1){1'b0}}, 1'b1};
	assign ns_ext    = {{(SUM_BITS-OFFSET_BITS){1'b0}}, ns_q};
	assign nlast_sum = ns_ext + {{(SUM_BITS-LENGTH_BITS){1'b0}}, nl_q}
		- {{(SUM_BITS-1){1'b0}}, 1'b1};
	assign end_ovf   = (nlast_sum[SUM_BITS-1:OFFSET_BITS] != '0);

	// Read rank against the entry count.
	assign rank_ext = {{CNT_BITS{1'b0}}, rank_q};
	assign occ_rext = {{RANK_BITS{1'b0}}, occ_q};
	assign rank_ok  = (rank_ext < occ_rext);

	// Scan: an entry is touched when it ends at or after the new start; the scan
	// stops at the first entry that starts past the new range.
	assign consume    = vld_s1 && !stop_q;
	assign stop_now   = consume && (rd_start > nlast_q);
	assign scan_issue = !stop_q && (issue_q < occ_q);
	assign scan_done  = stop_q || ((issue_q >= occ_q) && !vld_s1);

	// Layout of the new table.
	assign right_c   = found_q && (last_end_q > nlast_q);
	assign touched_c = hi_q - lo_q;
	assign count_c   = {1'b0, occ_q} - {1'b0, touched_c} + {{(CNT_BITS-1){1'b0}}, 2'd1}
		+ {{CNT_BITS{1'b0}}, left_q} + {{CNT_BITS{1'b0}}, right_c};
	assign full_c    = (count_c > (CNT_BITS+1)'(TABLE_ENTRIES));
	assign delta_c   = {{(DLT_BITS-1){1'b0}}, 1'b1} + {{(DLT_BITS-1){1'b0}}, left_q}
		+ {{(DLT_BITS-1){1'b0}}, right_c} - {2'b00, touched_c};

	// Move: entries above the overlap shift by delta.
	assign delta_pos  = !delta_q[DLT_BITS-1] && (delta_q != '0);
	assign move_issue = (remain_q != '0);
	assign dest_sum   = {2'b00, idx_s1} + delta_q;

	// Addresses and lengths of the pieces written after the move.
	assign addr_new   = {1'b0, lo_q} + {{CNT_BITS{1'b0}}, left_q};
	assign addr_right = addr_new + {{CNT_BITS{1'b0}}, 1'b1};
	assign left_len   = ns_ext - {{(SUM_BITS-OFFSET_BITS){1'b0}}, ls_q};
	assign right_len  = {{(SUM_BITS-OFFSET_BITS){1'b0}}, last_end_q}
		- {{(SUM_BITS-OFFSET_BITS){1'b0}}, nlast_q};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM port control.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (mode_q) begin
					state_d = ST_READ;
				end else if ((nl_q == '0) || end_ovf) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_READ: begin
				ram_raddr = rank_ext[IDX_BITS-1:0];
				state_d   = rank_ok ? ST_RDATA : ST_EMIT;
			end
			ST_RDATA: begin
				state_d = ST_EMIT;
			end
			ST_SCAN: begin
				ram_raddr = issue_q[IDX_BITS-1:0];
				if (scan_done) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = full_c ? ST_EMIT : ST_MOVE;
			end
			ST_MOVE: begin
				ram_raddr = issue_q[IDX_BITS-1:0];
				ram_we    = vld_s1;
				ram_waddr = dest_sum[IDX_BITS-1:0];
				ram_wdata = ram_rdata;
				if (!move_issue && !vld_s1) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				unique case (piece_q)
					2'd0: begin
						ram_we    = left_q;
						ram_waddr = lo_q[IDX_BITS-1:0];
						ram_wdata = {ls_q, left_len[LENGTH_BITS-1:0], lown_q};
					end
					2'd1: begin
						ram_we    = 1'b1;
						ram_waddr = addr_new[IDX_BITS-1:0];
						ram_wdata = {ns_q, nl_q, no_q};
					end
					2'd2: begin
						ram_we    = right_q;
						ram_waddr = addr_right[IDX_BITS-1:0];
						ram_wdata = {nlast_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1},
							right_len[LENGTH_BITS-1:0], rown_q};
						state_d   = ST_EMIT;
					end
					default: begin
						state_d = ST_EMIT;
					end
				endcase
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Entry count and read pipeline flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ((state_q == ST_SCAN) && scan_issue)
				|| ((state_q == ST_MOVE) && move_issue);
			if ((state_q == ST_PUT) && (piece_q == 2'd2)) begin
				occ_q <= new_occ_q;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q <= mode;
					ns_q   <= range_start;
					nl_q   <= range_length;
					no_q   <= owner_id;
					rank_q <= read_rank;
				end
			end
			ST_CHECK: begin
				nlast_q      <= nlast_sum[OFFSET_BITS-1:0];
				issue_q      <= '0;
				lo_q         <= occ_q;
				hi_q         <= occ_q;
				found_q      <= 1'b0;
				stop_q       <= 1'b0;
				left_q       <= 1'b0;
				res_start_q  <= '0;
				res_length_q <= '0;
				res_owner_q  <= '0;
				res_occ_q    <= occ_q;
				res_status_q <= (nl_q == '0) ? STAT_ZERO_LEN : STAT_END_OVF;
			end
			ST_READ: begin
				res_status_q <= STAT_RANK;
			end
			ST_RDATA: begin
				res_status_q <= STAT_OK;
				res_start_q  <= rd_start;
				res_length_q <= rd_len;
				res_owner_q  <= rd_own;
			end
			ST_SCAN: begin
				if (scan_issue) begin
					issue_q <= issue_q + {{(CNT_BITS-1){1'b0}}, 1'b1};
				end
				if (stop_now) begin
					stop_q <= 1'b1;
					hi_q   <= idx_s1;
					if (!found_q) begin
						lo_q <= idx_s1;
					end
				end else if (consume && (rd_end >= ns_ext)) begin
					// Touched entry: the first one may leave a left piece, the
					// latest one may leave a right piece.
					if (!found_q) begin
						found_q <= 1'b1;
						lo_q    <= idx_s1;
						left_q  <= (rd_start < ns_q);
						ls_q    <= rd_start;
						lown_q  <= rd_own;
					end
					last_end_q <= rd_end[OFFSET_BITS-1:0];
					rown_q     <= rd_own;
				end
			end
			ST_CALC: begin
				right_q   <= right_c;
				new_occ_q <= count_c[CNT_BITS-1:0];
				delta_q   <= delta_c;
				piece_q   <= 2'd0;
				remain_q  <= (delta_c == '0) ? '0 : (occ_q - hi_q);
				if (!delta_c[DLT_BITS-1] && (delta_c != '0)) begin
					issue_q <= occ_q - {{(CNT_BITS-1){1'b0}}, 1'b1};
				end else begin
					issue_q <= hi_q;
				end
				res_status_q <= STAT_FULL;
			end
			ST_MOVE: begin
				if (move_issue) begin
					remain_q <= remain_q - {{(CNT_BITS-1){1'b0}}, 1'b1};
					if (delta_pos) begin
						issue_q <= issue_q - {{(CNT_BITS-1){1'b0}}, 1'b1};
					end else begin
						issue_q <= issue_q + {{(CNT_BITS-1){1'b0}}, 1'b1};
					end
				end
			end
			ST_PUT: begin
				piece_q      <= piece_q + 2'd1;
				res_status_q <= STAT_OK;
				res_occ_q    <= new_occ_q;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Result outputs; the entry count is reported modulo 128.
	assign total_ext  = {{TOTAL_BITS{1'b0}}, res_occ_q};
	assign res_total  = total_ext[TOTAL_BITS-1:0];
	assign res_status = res_status_q;
	assign res_start  = res_start_q;
	assign res_length = res_length_q;
	assign res_owner  = res_owner_q;

endmodule
`default_nettype wire

@@ design/interval_overlay_table.sv @@
// Top level of the interval overlay table: entry RAM, sequencer and output register.
// Depends on iot_pkg, iot_ram and iot_ctrl.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps up to TABLE_ENTRIES non-overlapping ranges sorted by start offset
// in a single entry RAM with one read and one write port. One transaction is worked
// on at a time. An insert reads each entry up to the first one that starts past the
// new range (one RAM read each) and then shifts each entry above the overlap that
// must move (one read and write each); the single RAM read port sets the pace. A
// finished result waits in the output register while the next transaction is taken.
module interval_overlay_table import iot_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   mode,
	input  wire logic [OFFSET_BITS-1:0] range_start,
	input  wire logic [LENGTH_BITS-1:0] range_length,
	input  wire logic [OWNER_BITS-1:0]  owner_id,
	input  wire logic [RANK_BITS-1:0]   read_rank,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [STATUS_BITS-1:0] status,
	output logic      [OFFSET_BITS-1:0] entry_start,
	output logic      [LENGTH_BITS-1:0] entry_length,
	output logic      [OWNER_BITS-1:0]  entry_owner,
	output logic      [TOTAL_BITS-1:0]  entry_total
);

	localparam int IDX_BITS   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ENTRY_BITS = OFFSET_BITS + LENGTH_BITS + OWNER_BITS;

	logic [IDX_BITS-1:0]    ram_raddr, ram_waddr;
	logic [ENTRY_BITS-1:0]  ram_rdata, ram_wdata;
	logic                   ram_we;
	logic                   res_valid, res_free, out_valid_q;
	logic [STATUS_BITS-1:0] res_status;
	logic [OFFSET_BITS-1:0] res_start;
	logic [LENGTH_BITS-1:0] res_length;
	logic [OWNER_BITS-1:0]  res_owner;
	logic [TOTAL_BITS-1:0]  res_total;

	iot_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iot_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.OFFSET_BITS   (OFFSET_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.range_start  (range_start),
		.range_length (range_length),
		.owner_id     (owner_id),
		.read_rank    (read_rank),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.res_valid    (res_valid),
		.res_free     (res_free),
		.res_status   (res_status),
		.res_start    (res_start),
		.res_length   (res_length),
		.res_owner    (res_owner),
		.res_total    (res_total)
	);

	// The output register can take a result when empty or being emptied.
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	// Result payload, loaded as the transaction moves into the register.
	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			status       <= res_status;
			entry_start  <= res_start;
			entry_length <= res_length;
			entry_owner  <= res_owner;
			entry_total  <= res_total;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ bench/tb_interval_overlay_table.sv @@
// Self-checking bench for interval_overlay_table: random and directed inserts and reads.
// Depends on iot_pkg and the design sources; a local range table predicts every result.
`timescale 1ns / 1ps
module tb_interval_overlay_table;
	import iot_pkg::*;

	localparam int ENTRIES  = DEF_TABLE_ENTRIES;
	localparam int OFF_BITS = DEF_OFFSET_BITS;
	localparam int LEN_BITS = DEF_LENGTH_BITS;
	localparam logic [63:0] OFF_MAX = (64'd1 << OFF_BITS) - 64'd1;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic                  mode;
		logic [OFF_BITS-1:0]   rstart;
		logic [LEN_BITS-1:0]   rlen;
		logic [OWNER_BITS-1:0] owner;
		logic [RANK_BITS-1:0]  rank;
	} range_req_t;

	typedef struct {
		logic [STATUS_BITS-1:0] status;
		logic [OFF_BITS-1:0]    estart;
		logic [LEN_BITS-1:0]    elen;
		logic [OWNER_BITS-1:0]  eowner;
		logic [TOTAL_BITS-1:0]  total;
	} range_resp_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic mode;
	logic [OFF_BITS-1:0] range_start;
	logic [LEN_BITS-1:0] range_length;
	logic [OWNER_BITS-1:0] owner_id;
	logic [RANK_BITS-1:0] read_rank;
	logic [STATUS_BITS-1:0] status;
	logic [OFF_BITS-1:0] entry_start;
	logic [LEN_BITS-1:0] entry_length;
	logic [OWNER_BITS-1:0] entry_owner;
	logic [TOTAL_BITS-1:0] entry_total;

	range_req_t  pending_items[$];
	range_resp_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	// Shadow copy of the range table.
	logic [63:0] tbl_start[ENTRIES];
	logic [63:0] tbl_len[ENTRIES];
	logic [31:0] tbl_owner[ENTRIES];
	int tbl_count = 0;

	interval_overlay_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .range_start(range_start), .range_length(range_length),
		.owner_id(owner_id), .read_rank(read_rank),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .entry_start(entry_start), .entry_length(entry_length),
		.entry_owner(entry_owner), .entry_total(entry_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Lays a range over the shadow table; returns the status of the insert.
	function automatic logic [STATUS_BITS-1:0] overlay_insert(logic [63:0] ns, logic [63:0] nl,
			logic [31:0] no);
		logic [63:0] ns_list[ENTRIES+3];
		logic [63:0] nl_list[ENTRIES+3];
		logic [31:0] no_list[ENTRIES+3];
		logic [63:0] nlast, olast;
		int lo, hi, n, cnt;
		bit left, right;
		lo = 0;
		n = 0;
		left = 0;
		right = 0;
		if (nl == 0)
			return STAT_ZERO_LEN;
		if (ns > OFF_MAX - (nl - 1))
			return STAT_END_OVF;
		nlast = ns + nl - 1;
		while (lo < tbl_count && tbl_start[lo] + tbl_len[lo] - 1 < ns)
			lo++;
		hi = lo;
		while (hi < tbl_count && tbl_start[hi] <= nlast)
			hi++;
		if (hi > lo) begin
			left = tbl_start[lo] < ns;
			right = tbl_start[hi-1] + tbl_len[hi-1] - 1 > nlast;
		end
		cnt = tbl_count - (hi - lo) + 1 + int'(left) + int'(right);
		if (cnt > ENTRIES)
			return STAT_FULL;
		for (int i = 0; i < lo; i++) begin
			ns_list[n] = tbl_start[i]; nl_list[n] = tbl_len[i]; no_list[n] = tbl_owner[i]; n++;
		end
		if (left) begin
			ns_list[n] = tbl_start[lo]; nl_list[n] = ns - tbl_start[lo];
			no_list[n] = tbl_owner[lo]; n++;
		end
		ns_list[n] = ns; nl_list[n] = nl; no_list[n] = no; n++;
		if (right) begin
			olast = tbl_start[hi-1] + tbl_len[hi-1] - 1;
			ns_list[n] = nlast + 1; nl_list[n] = olast - nlast; no_list[n] = tbl_owner[hi-1]; n++;
		end
		for (int i = hi; i < tbl_count; i++) begin
			ns_list[n] = tbl_start[i]; nl_list[n] = tbl_len[i]; no_list[n] = tbl_owner[i]; n++;
		end
		for (int i = 0; i < n; i++) begin
			tbl_start[i] = ns_list[i]; tbl_len[i] = nl_list[i]; tbl_owner[i] = no_list[i];
		end
		tbl_count = n;
		return STAT_OK;
	endfunction

	// Works out the result of one transaction and updates the shadow table.
	function automatic range_resp_t overlay_predict(range_req_t it);
		range_resp_t r;
		r.estart = '0;
		r.elen = '0;
		r.eowner = '0;
		if (it.mode == 1'b0) begin
			r.status = overlay_insert(64'(it.rstart), 64'(it.rlen), it.owner);
		end else if (int'(it.rank) < tbl_count) begin
			r.status = STAT_OK;
			r.estart = tbl_start[it.rank][OFF_BITS-1:0];
			r.elen = tbl_len[it.rank][LEN_BITS-1:0];
			r.eowner = tbl_owner[it.rank];
		end else begin
			r.status = STAT_RANK;
		end
		r.total = TOTAL_BITS'(tbl_count);
		return r;
	endfunction

	function automatic range_req_t make_item(logic m, logic [63:0] s, logic [63:0] l,
			logic [31:0] o, int rk);
		range_req_t it;
		it.mode = m;
		it.rstart = s[OFF_BITS-1:0];
		it.rlen = l[LEN_BITS-1:0];
		it.owner = o;
		it.rank = RANK_BITS'(rk);
		return it;
	endfunction

	// Appends one transaction to the tail of the sender's queue.
	task automatic queue_item(range_req_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic range_req_t random_item();
		int kind;
		logic [63:0] wide;
		kind = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (kind < 45)
			return make_item(1'b0, 64'($urandom_range(0, 8191)), 64'($urandom_range(1, 512)),
				$urandom, $urandom_range(0, 63));
		else if (kind < 60)
			return make_item(1'b1, wide, 64'($urandom), $urandom, $urandom_range(0, 15));
		else if (kind < 75)
			return make_item(1'b1, wide, 64'($urandom), $urandom, $urandom_range(0, 63));
		else if (kind < 82)
			return make_item(1'b0, wide, 64'd0, $urandom, $urandom_range(0, 63));
		else if (kind < 89)
			return make_item(1'b0, OFF_MAX - 64'($urandom_range(0, 40)),
				64'($urandom_range(1, 80)), $urandom, $urandom_range(0, 63));
		else if (kind < 95)
			return make_item(1'b0, wide, 64'($urandom), $urandom, $urandom_range(0, 63));
		else
			return make_item(1'b0, 64'($urandom_range(0, 8191)),
				64'($urandom_range(1, 20000)), $urandom, $urandom_range(0, 63));
	endfunction

	// Sender: presents queued transactions, idling at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					overlay_predict('{mode, range_start, range_length, owner_id, read_rank}));
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					range_req_t it;
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					mode <= it.mode;
					range_start <= it.rstart;
					range_length <= it.rlen;
					owner_id <= it.owner;
					read_rank <= it.rank;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls at random and checks each result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result expected none actual status %0d", $time, status);
					errors++;
				end else begin
					range_resp_t e;
					e = expected_results.pop_front();
					if (status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status, status);
						errors++;
					end
					if (entry_start !== e.estart) begin
						$display("%0t: entry_start expected %h actual %h", $time, e.estart,
							entry_start);
						errors++;
					end
					if (entry_length !== e.elen) begin
						$display("%0t: entry_length expected %h actual %h", $time, e.elen,
							entry_length);
						errors++;
					end
					if (entry_owner !== e.eowner) begin
						$display("%0t: entry_owner expected %h actual %h", $time, e.eowner,
							entry_owner);
						errors++;
					end
					if (entry_total !== e.total) begin
						$display("%0t: entry_total expected %0d actual %0d", $time, e.total,
							entry_total);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic drain_all();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	// Stimulus: a directed part, then phases of random traffic under different idling.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		mode = 1'b0;
		range_start = '0;
		range_length = '0;
		owner_id = '0;
		read_rank = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty read, zero length, top of offset range, overflow, splits.
		queue_item(make_item(1'b1, 0, 0, 0, 0));
		queue_item(make_item(1'b0, 100, 0, 32'h1, 0));
		queue_item(make_item(1'b0, OFF_MAX, 1, 32'hFFFF_FFFF, 63));
		queue_item(make_item(1'b0, OFF_MAX, 2, 32'h2, 0));
		queue_item(make_item(1'b0, OFF_MAX - 5, 64'(1) << LEN_BITS - 1, 32'h3, 0));
		queue_item(make_item(1'b0, 0, (64'd1 << LEN_BITS) - 1, 32'hFFFF_FFFF, 0));
		queue_item(make_item(1'b0, 1000, 50, 32'hA, 0));
		queue_item(make_item(1'b0, 0, 1, 32'hB, 0));
		queue_item(make_item(1'b0, 1010, 200, 32'hC, 0));
		for (int k = 0; k < 6; k++)
			queue_item(make_item(1'b1, 0, 0, 0, k));
		queue_item(make_item(1'b1, 0, 0, 0, 63));
		queue_item(make_item(1'b0, 0, (64'd1 << LEN_BITS) - 1, 32'h0, 0));
		queue_item(make_item(1'b1, 0, 0, 0, 0));
		drain_all();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 30) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 30) : 0;
			// Fill with disjoint unit ranges until the table refuses, then read the top rank and one at random.
			for (int k = 0; k < 66; k++)
				queue_item(make_item(1'b0, 64'(30000 + 4 * k), 1, $urandom, 0));
			queue_item(make_item(1'b0, 29000, 1, 32'h5, 0));
			queue_item(make_item(1'b1, 0, 0, 0, 63));
			queue_item(make_item(1'b1, 0, 0, 0, $urandom_range(0, 63)));
			// Lay one range over everything from offset 0 to past the fill area.
			queue_item(make_item(1'b0, 0, 40000, $urandom, 0));
			for (int k = 0; k < 280; k++)
				queue_item(random_item());
			// Hold the sender until every result is back.
			drain_all();
		end

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
